// File: hw/rtl/ffd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants of the fractional feedback delay: operation
// classes passed from the front part to the back part, the configuration
// flag group, register indexes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package ffd_pkg;

  typedef enum logic [1:0] {
    OP_MUTE = 2'd0,
    OP_HOLD = 2'd1,
    OP_NORM = 2'd2
  } op_e;

  typedef struct packed {
    logic mute;
    logic hold_mode;
    logic feedback_guard;
  } cfg_flags_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LOOP_LENGTH    = 2'd0;
  localparam logic [1:0] REG_MUTE           = 2'd1;
  localparam logic [1:0] REG_HOLD_MODE      = 2'd2;
  localparam logic [1:0] REG_FEEDBACK_GUARD = 2'd3;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam int FRAC_BITS   = 8;      // fraction bits of the delay
  localparam int GAIN_BITS   = 16;     // Q2.14 gain
  localparam int GAIN_FRAC   = 14;
  localparam int GUARD_GAIN  = 16220;  // 0.99 in Q2.14
  localparam int FLUSH_LSB   = 8;
  localparam int QUEUE_DEPTH = 2;

endpackage

// File: hw/rtl/ffd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module ffd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ffd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_front
// Accepts input items, classifies them as mute, hold or normal, clamps the
// delay and the gain, and works out the tap and write addresses. Owns the
// write and hold positions. A bit-serial remainder unit wraps positions that
// lie past a shortened loop.
// ----------------------------------------------------------------------------
module ffd_front #(
  parameter int LINE_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  ffd_pkg::cfg_flags_t                               cfg_flags_i,
  input  logic [$clog2(LINE_DEPTH)-1:0]                     loop_length_i,
  input  logic                                              block_i,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]                     in_sample_i,
  input  logic [$clog2(LINE_DEPTH)+ffd_pkg::FRAC_BITS-1:0]  delay_amount_i,
  input  logic signed [ffd_pkg::GAIN_BITS-1:0]              feedback_gain_i,
  output logic                                              q_valid_o,
  input  logic                                              q_ready_i,
  output ffd_pkg::op_e                                      q_op_o,
  output logic [$clog2(LINE_DEPTH)-1:0]                     q_rd1_o,
  output logic [$clog2(LINE_DEPTH)-1:0]                     q_rd2_o,
  output logic [$clog2(LINE_DEPTH)-1:0]                     q_wr_o,
  output logic [ffd_pkg::FRAC_BITS-1:0]                     q_frac_o,
  output logic signed [ffd_pkg::GAIN_BITS-1:0]              q_gain_o,
  output logic signed [SAMPLE_BITS-1:0]                     q_sample_o
);

  import ffd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int DW = AW + FRAC_BITS;
  localparam int CW = $clog2(AW + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(AW);
  localparam logic signed [GAIN_BITS-1:0] G_MAX = GAIN_BITS'(GUARD_GAIN);
  localparam logic signed [GAIN_BITS-1:0] G_MIN = -G_MAX;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_TAP  = 3'd1;
  localparam logic [2:0] F_MODH = 3'd2;
  localparam logic [2:0] F_MODW = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [AW-1:0]               write_pos_q, write_pos_d;
  logic [AW-1:0]               hold_pos_q, hold_pos_d;
  logic [AW-1:0]               len_q, len_d;
  logic [AW-1:0]               idel_q, idel_d;
  logic [AW-1:0]               phs_q, phs_d;
  logic [AW-1:0]               t1_q, t1_d;
  logic [AW-1:0]               t2_q, t2_d;
  logic [FRAC_BITS-1:0]        frac_q, frac_d;
  logic signed [GAIN_BITS-1:0] gain_q, gain_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  op_e                         op_q, op_d;
  logic [AW:0]                 mod_v_q, mod_v_d;
  logic [AW-1:0]               mod_r_q, mod_r_d;
  logic [CW-1:0]               mod_cnt_q, mod_cnt_d;

  logic [AW-1:0]               len_c;
  logic [DW-1:0]               d_max_c, d_c;
  logic signed [GAIN_BITS-1:0] g_c;
  logic [AW-1:0]               phs_c;
  logic [AW-1:0]               t1_c, t2_c, wp_inc_c, wp_next_c;
  logic [AW:0]                 r_sh_c;
  logic [AW-1:0]               r_nx_c, mod_res_c;
  logic                        mod_lt_c, mod_eq_c, mod_done_c;
  logic                        in_fire;

  assign in_ready_o = (state_q == F_IDLE) && !block_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Effective loop length, delay clamp and gain guard.
  always_comb begin
    if (loop_length_i < AW'(2)) begin
      len_c = AW'(2);
    end else if (loop_length_i > AW'(LINE_DEPTH - 1)) begin
      len_c = AW'(LINE_DEPTH - 1);
    end else begin
      len_c = loop_length_i;
    end
    d_max_c = {len_c - AW'(1), {FRAC_BITS{1'b0}}};
    d_c = delay_amount_i;
    if (d_c < DW'(1 << FRAC_BITS)) begin
      d_c = DW'(1 << FRAC_BITS);
    end
    if (d_c > d_max_c) begin
      d_c = d_max_c;
    end
    g_c = feedback_gain_i;
    if (cfg_flags_i.feedback_guard) begin
      if (g_c > G_MAX) begin
        g_c = G_MAX;
      end
      if (g_c < G_MIN) begin
        g_c = G_MIN;
      end
    end
    phs_c = (write_pos_q >= len_c) ? '0 : write_pos_q;
  end

  // Tap addresses; phs_q and idel_q are both below len_q.
  always_comb begin
    t1_c      = (phs_q >= idel_q) ? (phs_q - idel_q) : (phs_q + len_q - idel_q);
    t2_c      = (t1_c != '0) ? (t1_c - AW'(1)) : (len_q - AW'(1));
    wp_inc_c  = phs_q + AW'(1);
    wp_next_c = (wp_inc_c == len_q) ? '0 : wp_inc_c;
  end

  // One restoring remainder step per cycle, with a shortcut for values that
  // are already in range or land exactly on the loop length.
  always_comb begin
    r_sh_c     = {mod_r_q, mod_v_q[AW]};
    r_nx_c     = (r_sh_c >= {1'b0, len_q}) ? AW'(r_sh_c - {1'b0, len_q}) : r_sh_c[AW-1:0];
    mod_lt_c   = (mod_cnt_q == '0) && (mod_v_q < {1'b0, len_q});
    mod_eq_c   = (mod_cnt_q == '0) && (mod_v_q == {1'b0, len_q});
    mod_done_c = mod_lt_c || mod_eq_c || (mod_cnt_q == CNT_LAST);
    if (mod_lt_c) begin
      mod_res_c = mod_v_q[AW-1:0];
    end else if (mod_eq_c) begin
      mod_res_c = '0;
    end else begin
      mod_res_c = r_nx_c;
    end
  end

  always_comb begin
    state_d     = state_q;
    write_pos_d = write_pos_q;
    hold_pos_d  = hold_pos_q;
    len_d       = len_q;
    idel_d      = idel_q;
    phs_d       = phs_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    frac_d      = frac_q;
    gain_d      = gain_q;
    sample_d    = sample_q;
    op_d        = op_q;
    mod_v_d     = mod_v_q << 1;
    mod_r_d     = r_nx_c;
    mod_cnt_d   = mod_cnt_q + CW'(1);
    unique case (state_q)
      F_IDLE: begin
        if (in_fire) begin
          sample_d = in_sample_i;
          gain_d   = g_c;
          frac_d   = d_c[FRAC_BITS-1:0];
          idel_d   = d_c[DW-1:FRAC_BITS];
          len_d    = len_c;
          phs_d    = phs_c;
          if (cfg_flags_i.mute) begin
            op_d    = OP_MUTE;
            state_d = F_PUSH;
          end else if (cfg_flags_i.hold_mode) begin
            op_d      = OP_HOLD;
            mod_v_d   = {1'b0, hold_pos_q} + (AW + 1)'(1);
            mod_r_d   = '0;
            mod_cnt_d = '0;
            state_d   = F_MODH;
          end else begin
            op_d    = OP_NORM;
            state_d = F_TAP;
          end
        end
      end
      F_TAP: begin
        t1_d        = t1_c;
        t2_d        = t2_c;
        hold_pos_d  = t1_c;
        write_pos_d = wp_next_c;
        state_d     = F_PUSH;
      end
      F_MODH: begin
        if (mod_done_c) begin
          hold_pos_d = mod_res_c;
          t1_d       = mod_res_c;
          mod_v_d    = {1'b0, write_pos_q} + (AW + 1)'(1);
          mod_r_d    = '0;
          mod_cnt_d  = '0;
          state_d    = F_MODW;
        end
      end
      F_MODW: begin
        if (mod_done_c) begin
          write_pos_d = mod_res_c;
          state_d     = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      write_pos_q <= '0;
      hold_pos_q  <= '0;
    end else begin
      state_q     <= state_d;
      write_pos_q <= write_pos_d;
      hold_pos_q  <= hold_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    idel_q    <= idel_d;
    phs_q     <= phs_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    frac_q    <= frac_d;
    gain_q    <= gain_d;
    sample_q  <= sample_d;
    op_q      <= op_d;
    mod_v_q   <= mod_v_d;
    mod_r_q   <= mod_r_d;
    mod_cnt_q <= mod_cnt_d;
  end

  assign q_valid_o  = (state_q == F_PUSH);
  assign q_op_o     = op_q;
  assign q_rd1_o    = t1_q;
  assign q_rd2_o    = t2_q;
  assign q_wr_o     = phs_q;
  assign q_frac_o   = frac_q;
  assign q_gain_o   = gain_q;
  assign q_sample_o = sample_q;

endmodule

// File: hw/rtl/ffd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_queue
// Short FIFO between the front and the back part, so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module ffd_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  import ffd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != NW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/ffd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_back
// Carries out queued items against the delay memory: two tap reads, the
// linear interpolation, the feedback multiply, flush and saturation, the
// write back, and the output register. Clears the memory after reset.
// ----------------------------------------------------------------------------
module ffd_back #(
  parameter int LINE_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  output logic                                 q_ready_o,
  input  ffd_pkg::op_e                         q_op_i,
  input  logic [$clog2(LINE_DEPTH)-1:0]        q_rd1_i,
  input  logic [$clog2(LINE_DEPTH)-1:0]        q_rd2_i,
  input  logic [$clog2(LINE_DEPTH)-1:0]        q_wr_i,
  input  logic [ffd_pkg::FRAC_BITS-1:0]        q_frac_i,
  input  logic signed [ffd_pkg::GAIN_BITS-1:0] q_gain_i,
  input  logic signed [SAMPLE_BITS-1:0]        q_sample_i,
  output logic                                 clearing_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_o
);

  import ffd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + FRAC_BITS + 2;   // interpolation product
  localparam int FW = SB + GAIN_BITS;       // feedback product
  localparam logic signed [PW-1:0] HALF_I = PW'(1 << (FRAC_BITS - 1));
  localparam logic signed [FW-1:0] HALF_F = FW'(1 << (GAIN_FRAC - 1));
  localparam logic signed [SB+1:0] FLUSH_P = (SB + 2)'(FLUSH_LSB);
  localparam logic signed [SB+1:0] FLUSH_N = -FLUSH_P;
  localparam logic signed [SB+2:0] MAX_V = (SB + 3)'((longint'(1) <<< (SB - 1)) - longint'(1));
  localparam logic signed [SB+2:0] MIN_V = -MAX_V - (SB + 3)'(1);
  localparam logic [AW-1:0] CLR_LAST = AW'(LINE_DEPTH - 1);

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_X1   = 3'd2;
  localparam logic [2:0] B_X2   = 3'd3;
  localparam logic [2:0] B_INT  = 3'd4;
  localparam logic [2:0] B_FB   = 3'd5;
  localparam logic [2:0] B_WR   = 3'd6;
  localparam logic [2:0] B_DONE = 3'd7;

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [SB+2:0] v);
    logic signed [SB+2:0] r;
    r = v;
    if (v > MAX_V) begin
      r = MAX_V;
    end else if (v < MIN_V) begin
      r = MIN_V;
    end
    return r[SB-1:0];
  endfunction

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SB-1:0]          out_sample_q, out_sample_d;
  op_e                           op_q, op_d;
  logic [AW-1:0]                 rd2_q, rd2_d;
  logic [AW-1:0]                 wr_q, wr_d;
  logic [FRAC_BITS-1:0]          frac_q, frac_d;
  logic signed [GAIN_BITS-1:0]   gain_q, gain_d;
  logic signed [SB-1:0]          sample_q, sample_d;
  logic signed [SB-1:0]          x1_q, x1_d;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic signed [SB-1:0]          res_q, res_d;
  logic signed [FW-1:0]          fprod_q, fprod_d;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [SB-1:0]                 ram_wdata, ram_rdata;

  logic signed [SB:0]            diff_c;
  logic signed [PW-1:0]          rnd_c;
  logic signed [SB+2:0]          o_sum_c;
  logic signed [FW-1:0]          feed_full_c;
  logic signed [SB+1:0]          feed_c;
  logic signed [SB+2:0]          w_sum_c;

  ffd_ram #(
    .WIDTH (SB),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign q_ready_o  = (state_q == B_IDLE);
  assign clearing_o = (state_q == B_CLR);

  // Datapath: interpolation and feedback, each product registered.
  always_comb begin
    diff_c      = $signed({ram_rdata[SB-1], ram_rdata}) - $signed({x1_q[SB-1], x1_q});
    rnd_c       = (prod_q + HALF_I) >>> FRAC_BITS;
    o_sum_c     = $signed({{3{x1_q[SB-1]}}, x1_q}) + $signed(rnd_c[SB+2:0]);
    feed_full_c = (fprod_q + HALF_F) >>> GAIN_FRAC;
    feed_c      = $signed(feed_full_c[SB+1:0]);
    // Tiny feedback terms are flushed so that the loop decays to silence.
    if ((feed_c <= FLUSH_P) && (feed_c >= FLUSH_N)) begin
      feed_c = '0;
    end
    w_sum_c = $signed({{3{sample_q[SB-1]}}, sample_q}) + $signed({feed_c[SB+1], feed_c});
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    op_d         = op_q;
    rd2_d        = rd2_q;
    wr_d         = wr_q;
    frac_d       = frac_q;
    gain_d       = gain_q;
    sample_d     = sample_q;
    x1_d         = x1_q;
    prod_d       = prod_q;
    res_d        = res_q;
    fprod_d      = fprod_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_q;
    ram_wdata    = w_sum_c[SB-1:0];
    ram_raddr    = (state_q == B_IDLE) ? q_rd1_i : rd2_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      B_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          op_d     = q_op_i;
          rd2_d    = q_rd2_i;
          wr_d     = q_wr_i;
          frac_d   = q_frac_i;
          gain_d   = q_gain_i;
          sample_d = q_sample_i;
          if (q_op_i == OP_MUTE) begin
            res_d   = '0;
            state_d = B_DONE;
          end else begin
            state_d = B_X1;
          end
        end
      end
      B_X1: begin
        if (op_q == OP_HOLD) begin
          res_d   = $signed(ram_rdata);
          state_d = B_DONE;
        end else begin
          x1_d    = $signed(ram_rdata);
          state_d = B_X2;
        end
      end
      B_X2: begin
        prod_d  = PW'($signed({1'b0, frac_q})) * PW'(diff_c);
        state_d = B_INT;
      end
      B_INT: begin
        res_d   = sat_sample(o_sum_c);
        state_d = B_FB;
      end
      B_FB: begin
        fprod_d = FW'(res_q) * FW'(gain_q);
        state_d = B_WR;
      end
      B_WR: begin
        ram_we    = 1'b1;
        ram_wdata = sat_sample(w_sum_c);
        state_d   = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = res_q;
          state_d      = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    op_q         <= op_d;
    rd2_q        <= rd2_d;
    wr_q         <= wr_d;
    frac_q       <= frac_d;
    gain_q       <= gain_d;
    sample_q     <= sample_d;
    x1_q         <= x1_d;
    prod_q       <= prod_d;
    res_q        <= res_d;
    fprod_q      <= fprod_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

endmodule

// File: hw/rtl/fractional_feedback_delay_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_feedback_delay_top
// Mono fractional delay line with linear interpolation and feedback. After
// reset the delay memory is cleared, during which no item is accepted;
// configuration writes are taken at any time. A front part clamps the delay
// and the gain and computes the tap and write addresses, and a two-entry
// queue hands its work to a back part that owns the single-read-port delay
// memory, so the front part can take a new item while the back part is
// still busy with earlier ones. A normal item goes in the back part through
// two sequential tap reads, the interpolation multiply, the feedback
// multiply and the write back; muted items skip all of these. In hold mode
// the bit-serial remainder unit of the front part wraps the positions,
// taking its shortcut when they lie inside the loop and stepping bit by bit
// when a shortened loop leaves them outside.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_top #(
  parameter int LINE_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [ffd_pkg::APB_ADDR_BITS-1:0]                 paddr,
  input  logic [ffd_pkg::APB_DATA_BITS-1:0]                 pwdata,
  output logic [ffd_pkg::APB_DATA_BITS-1:0]                 prdata,
  output logic                                              pready,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]                     in_sample_i,
  input  logic [$clog2(LINE_DEPTH)+ffd_pkg::FRAC_BITS-1:0]  delay_amount_i,
  input  logic signed [ffd_pkg::GAIN_BITS-1:0]              feedback_gain_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]                     out_sample_o
);

  import ffd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int OW = $bits(op_e);
  localparam int QW = OW + 3 * AW + FRAC_BITS + GAIN_BITS + SAMPLE_BITS;

  logic [AW-1:0] loop_length_q, loop_length_d;
  cfg_flags_t    flags_q, flags_d;
  logic          cfg_we;

  logic                          clearing;
  logic                          f_valid, f_ready;
  op_e                           f_op;
  logic [AW-1:0]                 f_rd1, f_rd2, f_wr;
  logic [FRAC_BITS-1:0]          f_frac;
  logic signed [GAIN_BITS-1:0]   f_gain;
  logic signed [SAMPLE_BITS-1:0] f_sample;
  logic [QW-1:0]                 push_data, pop_data;
  logic                          b_valid, b_ready;
  op_e                           b_op;
  logic [AW-1:0]                 b_rd1, b_rd2, b_wr;
  logic [FRAC_BITS-1:0]          b_frac;
  logic signed [GAIN_BITS-1:0]   b_gain;
  logic signed [SAMPLE_BITS-1:0] b_sample;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    loop_length_d = loop_length_q;
    flags_d       = flags_q;
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_LOOP_LENGTH:    loop_length_d          = pwdata[AW-1:0];
        REG_MUTE:           flags_d.mute           = pwdata[0];
        REG_HOLD_MODE:      flags_d.hold_mode      = pwdata[0];
        REG_FEEDBACK_GUARD: flags_d.feedback_guard = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOOP_LENGTH:    prdata = APB_DATA_BITS'(loop_length_q);
      REG_MUTE:           prdata = APB_DATA_BITS'(flags_q.mute);
      REG_HOLD_MODE:      prdata = APB_DATA_BITS'(flags_q.hold_mode);
      REG_FEEDBACK_GUARD: prdata = APB_DATA_BITS'(flags_q.feedback_guard);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_length_q <= AW'(LINE_DEPTH - 1);
      flags_q       <= '0;
    end else begin
      loop_length_q <= loop_length_d;
      flags_q       <= flags_d;
    end
  end

  ffd_front #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_flags_i     (flags_q),
    .loop_length_i   (loop_length_q),
    .block_i         (clearing),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_sample_i     (in_sample_i),
    .delay_amount_i  (delay_amount_i),
    .feedback_gain_i (feedback_gain_i),
    .q_valid_o       (f_valid),
    .q_ready_i       (f_ready),
    .q_op_o          (f_op),
    .q_rd1_o         (f_rd1),
    .q_rd2_o         (f_rd2),
    .q_wr_o          (f_wr),
    .q_frac_o        (f_frac),
    .q_gain_o        (f_gain),
    .q_sample_o      (f_sample)
  );

  assign push_data = {f_op, f_rd1, f_rd2, f_wr, f_frac, f_gain, f_sample};

  ffd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (pop_data)
  );

  assign b_op     = op_e'(pop_data[QW-1 -: OW]);
  assign b_rd1    = pop_data[QW-OW-1 -: AW];
  assign b_rd2    = pop_data[QW-OW-AW-1 -: AW];
  assign b_wr     = pop_data[QW-OW-2*AW-1 -: AW];
  assign b_frac   = pop_data[FRAC_BITS+GAIN_BITS+SAMPLE_BITS-1 -: FRAC_BITS];
  assign b_gain   = $signed(pop_data[GAIN_BITS+SAMPLE_BITS-1 -: GAIN_BITS]);
  assign b_sample = $signed(pop_data[SAMPLE_BITS-1:0]);

  ffd_back #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (b_valid),
    .q_ready_o    (b_ready),
    .q_op_i       (b_op),
    .q_rd1_i      (b_rd1),
    .q_rd2_i      (b_rd2),
    .q_wr_i       (b_wr),
    .q_frac_i     (b_frac),
    .q_gain_i     (b_gain),
    .q_sample_i   (b_sample),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o)
  );

`ifndef NO_ASSERTIONS
  // No item may enter while the memory is still being cleared.
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o
  ) else $error("item accepted during the clearing pass");

  // No result can exist before the clearing pass has finished.
  a_no_result_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> (!out_valid_o && !b_valid)
  ) else $error("result or queued item present during the clearing pass");
`endif

endmodule

// File: test/fractional_feedback_delay_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_feedback_delay_top_tb
// Self-checking bench for the fractional feedback delay. Items go in on a
// valid/ready channel with random gaps. A model of the delay line in this
// file computes each output sample on input acceptance, and every output
// item is compared against the oldest pending sample. Directed items cover
// the field extremes, the gain guard, the flush window, hold replay and
// mute. Random phases then sweep the loop length and the mode flags, with
// back pressure from the output side.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_top_tb;
  import ffd_pkg::*;

  localparam int         DEPTH        = 16384;
  localparam int         SB           = 24;
  localparam int         DW           = $clog2(DEPTH) + FRAC_BITS;
  localparam int         DRAIN_CYCLES = 64;
  localparam longint     CYCLE_LIMIT  = 600000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [SB-1:0]   in_sample_i = '0;
  logic [DW-1:0]          delay_amount_i = '0;
  logic signed [GAIN_BITS-1:0] feedback_gain_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [SB-1:0]   out_sample_o;

  fractional_feedback_delay_top #(
    .LINE_DEPTH (DEPTH),
    .SAMPLE_BITS(SB)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_sample_i    (in_sample_i),
    .delay_amount_i (delay_amount_i),
    .feedback_gain_i(feedback_gain_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_sample_o   (out_sample_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state of the delay line.
  logic signed [SB-1:0] line_mem [DEPTH];
  longint               wr_pos = 0;
  longint               replay_pos = 0;
  logic [13:0]          cfg_loop = 14'd16383;
  logic                 cfg_mute = 1'b0;
  logic                 cfg_hold = 1'b0;
  logic                 cfg_guard = 1'b0;

  logic signed [SB-1:0] pending_out [$];
  logic signed [SB-1:0] want;
  int                   fail_count = 0;
  longint               cycle_count = 0;

  bit                   tx_steady = 1'b0;
  bit                   rx_steady = 1'b0;
  int                   rx_wait = 0;
  int                   hold_off_left = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) line_mem[i] = '0;
  end

  function automatic longint loop_len_eff();
    longint len;
    len = cfg_loop;
    if (len < 2) len = 2;
    if (len > DEPTH - 1) len = DEPTH - 1;
    return len;
  endfunction

  function automatic longint sat_sample(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SB - 1)) - 1;
    lo = -(longint'(1) <<< (SB - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advances the model by one item and returns the sample it puts out.
  function automatic logic signed [SB-1:0] next_delay_out(
    input logic signed [SB-1:0]        smp,
    input logic [DW-1:0]               dly,
    input logic signed [GAIN_BITS-1:0] gain
  );
    longint len, d, idel, frac, g, phs, t1, t2, x1, x2, o, feed, w;
    len = loop_len_eff();
    if (cfg_mute) return '0;
    if (cfg_hold) begin
      replay_pos = (replay_pos + 1) % len;
      o = line_mem[replay_pos];
      wr_pos = (wr_pos + 1) % len;
      return o[SB-1:0];
    end

    d = dly;
    if (d < 256) d = 256;
    if (d > ((len - 1) <<< FRAC_BITS)) d = (len - 1) <<< FRAC_BITS;
    idel = d >>> FRAC_BITS;
    frac = d & 255;

    g = gain;
    if (cfg_guard) begin
      if (g > GUARD_GAIN) g = GUARD_GAIN;
      if (g < -GUARD_GAIN) g = -GUARD_GAIN;
    end

    // A write position left beyond a shortened loop restarts at zero.
    phs = (wr_pos >= len) ? 0 : wr_pos;
    t1 = (phs >= idel) ? (phs - idel) : (phs + len - idel);
    t2 = (t1 >= 1) ? (t1 - 1) : (len - 1);
    replay_pos = t1;

    x1 = line_mem[t1];
    x2 = line_mem[t2];
    // Arithmetic shift of the biased value rounds halves toward plus infinity.
    o = sat_sample(x1 + ((frac * (x2 - x1) + 128) >>> FRAC_BITS));

    feed = (o * g + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (feed <= FLUSH_LSB && feed >= -FLUSH_LSB) feed = 0;
    w = sat_sample(longint'(smp) + feed);
    line_mem[phs] = w[SB-1:0];

    phs = phs + 1;
    if (phs >= len) phs = 0;
    wr_pos = phs;
    return o[SB-1:0];
  endfunction

  // Input monitor: every accepted item gets its output sample predicted.
  always @(posedge clk_i) begin
    if (in_valid_i === 1'b1 && in_ready_o === 1'b1) begin
      pending_out.push_back(next_delay_out(in_sample_i, delay_amount_i, feedback_gain_i));
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i) begin
      rx_wait = rx_steady ? 0 : $urandom_range(0, 17);
      if (pending_out.size() == 0) begin
        fail_count++;
        $display("%0t: out_sample item with nothing pending, expected none, actual %0d",
                 $time, out_sample_o);
      end else begin
        want = pending_out.pop_front();
        if (out_sample_o !== want) begin
          fail_count++;
          $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                   $time, want, out_sample_o);
        end
      end
    end
  end

  // Output side: random stalls per item, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i <= 1'b0;
      hold_off_left--;
    end else if (rx_wait > 0) begin
      out_ready_i <= 1'b0;
      rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(
    input logic signed [SB-1:0]        smp,
    input logic [DW-1:0]               dly,
    input logic signed [GAIN_BITS-1:0] gain
  );
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_sample_i     <= smp;
    delay_amount_i  <= dly;
    feedback_gain_i <= gain;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Stops offering items and waits until every pending sample has come out,
  // then lets the back end finish its write back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_out.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_LOOP_LENGTH:    cfg_loop  = value[13:0];
      REG_MUTE:           cfg_mute  = value[0];
      REG_HOLD_MODE:      cfg_hold  = value[0];
      REG_FEEDBACK_GUARD: cfg_guard = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(SB - 1){1'b1}}};
      1:       return {1'b1, {(SB - 1){1'b0}}};
      2:       return SB'(int'($urandom_range(0, 40)) - 20);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic signed [GAIN_BITS-1:0] rand_gain();
    int g;
    case ($urandom_range(0, 3))
      0:       g = 16384 + int'($urandom_range(0, 1200)) - 600;
      1:       g = -16384 + int'($urandom_range(0, 1200)) - 600;
      default: g = $urandom;
    endcase
    return g[GAIN_BITS-1:0];
  endfunction

  function automatic logic [DW-1:0] rand_delay();
    longint len;
    len = loop_len_eff();
    if ($urandom_range(0, 3) == 0) return DW'($urandom);
    return DW'($urandom_range(0, int'(len << FRAC_BITS) + 300));
  endfunction

  task automatic test_extremes();
    send_item(24'sh7FFFFF, 22'd256, 16'sd0);
    send_item(-24'sh800000, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd0, 16'sd16384);
    send_item(24'sd0, 22'h3FFFFF, 16'sh7FFF);
    send_item(24'sh7FFFFF, 22'd255, -16'sh8000);
    send_item(24'sd0, 22'd256, 16'sh7FFF);
    send_item(24'sd0, 22'd256, -16'sh8000);
    // Feed exactly at and just past the flush window, both signs.
    send_item(24'sd9, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sd16384);
    send_item(24'sd8, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sd16384);
    send_item(-24'sd9, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sd16384);
    send_item(-24'sd8, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sd16384);
    // Half-way fractions exercise the upward rounding of the interpolation.
    send_item(24'sd1, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd384, 16'sd0);
    send_item(-24'sd1, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd384, 16'sd0);
    send_item(24'sh123456, 22'h1FF, 16'sd8192);
    wait_drained();
  endtask

  task automatic test_gain_guard();
    write_reg(REG_FEEDBACK_GUARD, 32'd1);
    send_item(24'sh7FFFFF, 22'd256, 16'sd0);
    send_item(24'sd0, 22'd256, 16'sh7FFF);
    send_item(24'sd0, 22'd256, -16'sh8000);
    send_item(24'sd0, 22'd256, 16'sd16220);
    send_item(24'sd0, 22'd256, 16'sd16221);
    send_item(24'sd0, 22'd256, -16'sd16221);
    send_item(24'sd0, 22'd256, -16'sd16220);
    wait_drained();
    write_reg(REG_FEEDBACK_GUARD, 32'd0);
  endtask

  task automatic test_loop_limits();
    // Lengths below two are raised to two; the old write position falls
    // outside the shortened loop.
    write_reg(REG_LOOP_LENGTH, 32'd0);
    for (int i = 0; i < 6; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_LOOP_LENGTH, 32'd1);
    for (int i = 0; i < 6; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_LOOP_LENGTH, 32'd3);
    for (int i = 0; i < 8; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_LOOP_LENGTH, 32'd16383);
    for (int i = 0; i < 8; i++) send_item(rand_sample(), DW'($urandom), rand_gain());
    wait_drained();
  endtask

  task automatic test_hold_replay();
    write_reg(REG_LOOP_LENGTH, 32'd40);
    for (int i = 0; i < 50; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_HOLD_MODE, 32'd1);
    for (int i = 0; i < 45; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    // Shorten the loop while replaying so both positions may lie outside it.
    write_reg(REG_LOOP_LENGTH, 32'd5);
    for (int i = 0; i < 12; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_HOLD_MODE, 32'd0);
    for (int i = 0; i < 12; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
  endtask

  task automatic test_mute();
    write_reg(REG_MUTE, 32'd1);
    for (int i = 0; i < 6; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    // Mute wins over hold.
    write_reg(REG_HOLD_MODE, 32'd1);
    for (int i = 0; i < 4; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_MUTE, 32'd0);
    for (int i = 0; i < 6; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    wait_drained();
    write_reg(REG_HOLD_MODE, 32'd0);
  endtask

  task automatic test_backpressure();
    write_reg(REG_LOOP_LENGTH, 32'd24);
    tx_steady = 1'b1;
    hold_off_left = 400;
    for (int i = 0; i < 60; i++) send_item(rand_sample(), rand_delay(), rand_gain());
    tx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sweep();
    logic [31:0] len_val;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 6))
        0:       len_val = 32'd2;
        1:       len_val = $urandom_range(0, 3);
        2:       len_val = 32'd16383;
        3:       len_val = $urandom_range(2, 64);
        4:       len_val = $urandom_range(2, 600);
        5:       len_val = $urandom_range(2, 20);
        default: len_val = $urandom;
      endcase
      write_reg(REG_LOOP_LENGTH, len_val);
      write_reg(REG_MUTE, {31'd0, $urandom_range(0, 11) == 0});
      write_reg(REG_HOLD_MODE, {31'd0, $urandom_range(0, 7) == 0});
      write_reg(REG_FEEDBACK_GUARD, {31'd0, $urandom_range(0, 1) == 1});
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) send_item(rand_sample(), rand_delay(), rand_gain());
      wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_gain_guard();
    test_loop_limits();
    test_hold_replay();
    test_mute();
    test_backpressure();
    test_random_sweep();

    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ffd_pkg.sv
hw/rtl/ffd_ram.sv
hw/rtl/ffd_front.sv
hw/rtl/ffd_queue.sv
hw/rtl/ffd_back.sv
hw/rtl/fractional_feedback_delay_top.sv
test/fractional_feedback_delay_top_tb.sv
